// ----- rtl/caf_pkg.sv -----
// Shared types and constants for the complementary attitude filter.
`timescale 1ns / 1ps
package caf_pkg;
   localparam int ATAN_LEN = 30;
   localparam logic signed [31:0] PI_Q24 = 32'sd52707179;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic [16:0] WEIGHT_RESET = 17'd64225;

   typedef struct packed {
      logic load;      // capture the transaction and start
      logic sqrt_step; // one square root digit
      logic cordic_init;
      logic cordic_step;
      logic blend;     // form the new angles
      logic mul_step;  // one blend product
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic cordic_done;
      logic mul_done;
   } status_type;

   function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            5'd0: r = 32'sd13176795;
            5'd1: r = 32'sd7778716;
            5'd2: r = 32'sd4110060;
            5'd3: r = 32'sd2086331;
            5'd4: r = 32'sd1047214;
            5'd5: r = 32'sd524117;
            5'd6: r = 32'sd262123;
            5'd7: r = 32'sd131069;
            5'd8: r = 32'sd65536;
            5'd9: r = 32'sd32768;
            5'd10: r = 32'sd16384;
            5'd11: r = 32'sd8192;
            5'd12: r = 32'sd4096;
            5'd13: r = 32'sd2048;
            5'd14: r = 32'sd1024;
            5'd15: r = 32'sd512;
            5'd16: r = 32'sd256;
            5'd17: r = 32'sd128;
            5'd18: r = 32'sd64;
            5'd19: r = 32'sd32;
            5'd20: r = 32'sd16;
            5'd21: r = 32'sd8;
            5'd22: r = 32'sd4;
            5'd23: r = 32'sd2;
            5'd24: r = 32'sd1;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction
endpackage

// ----- rtl/caf_ctrl.sv -----
// Sequencer for the complementary attitude filter.
`timescale 1ns / 1ps
module caf_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  caf_pkg::status_type status,
   output caf_pkg::cmd_type cmd
);
   import caf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SQRT, S_CINIT, S_CORDIC, S_BLEND, S_MUL, S_DONE
   } state_type;

   state_type state_ff;
   logic rsp_valid_ff;

   // The result register frees once taken; a new transaction may then start.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = req_valid && req_ready;
      cmd.sqrt_step = (state_ff == S_SQRT);
      cmd.cordic_init = (state_ff == S_CINIT);
      cmd.cordic_step = (state_ff == S_CORDIC);
      cmd.blend = (state_ff == S_BLEND);
      cmd.mul_step = (state_ff == S_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd.load) state_ff <= S_SQRT;
            S_SQRT: if (status.sqrt_done) state_ff <= S_CINIT;
            S_CINIT: state_ff <= S_CORDIC;
            S_CORDIC: if (status.cordic_done) state_ff <= S_BLEND;
            S_BLEND: state_ff <= S_MUL;
            S_MUL: if (status.mul_done) state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/caf_datapath.sv -----
// Datapath: square root, two-lane CORDIC, integration and blend.
`timescale 1ns / 1ps
module caf_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  caf_pkg::cmd_type cmd,
   output caf_pkg::status_type status,
   input  logic [16:0] csr_gyro_weight,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   input  logic [15:0] req_time_step,
   output logic signed [31:0] roll_angle,
   output logic signed [31:0] pitch_angle,
   output logic signed [31:0] yaw_angle
);
   import caf_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);

   // Captured transaction.
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic [15:0] dt_ff;

   // Restoring square root of (ay^2+az^2)<<28: 60-bit radicand, 30-bit root.
   logic [59:0] rad_ff, rad_in;
   logic [31:0] rem_ff, rem_in;
   logic [29:0] root_ff, root_in;
   logic [4:0] sq_cnt_ff;
   logic [31:0] sumsq;

   // Two CORDIC lanes (roll and pitch) step together under one counter.
   logic signed [33:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [31:0] z0_ff, z1_ff;
   logic [4:0] c_cnt_ff;

   // Blend: one 35x18 product per cycle, four products in all.
   logic signed [34:0] gr_ff, gp_ff, ar_ff, ap_ff;
   logic [16:0] w_ff;
   logic [2:0] m_cnt_ff;
   logic signed [53:0] acc_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;

   assign roll_angle = roll_ff;
   assign pitch_angle = pitch_ff;
   assign yaw_angle = yaw_ff;

   // The radicand is formed from the incoming transaction as it is captured.
   assign sumsq = 32'(req_accel_y * req_accel_y) + 32'(req_accel_z * req_accel_z);

   always_comb begin
      logic [31:0] trial;
      trial = {rem_ff[29:0], rad_ff[59:58]} - {root_ff, 2'b01};
      rad_in = {rad_ff[57:0], 2'b00};
      if (!trial[31] || rem_ff[31:30] != 2'b00) begin
         rem_in = trial;
         root_in = {root_ff[28:0], 1'b1};
      end else begin
         rem_in = {rem_ff[29:0], rad_ff[59:58]};
         root_in = {root_ff[28:0], 1'b0};
      end
   end

   function automatic logic signed [33:0] fshift(input logic signed [33:0] v,
                                                  input logic [4:0] s);
      return v >>> s;
   endfunction

   function automatic logic signed [34:0] incr(input logic signed [15:0] r,
                                               input logic [15:0] dt);
      logic signed [32:0] p;
      begin
         p = 33'(r * $signed({1'b0, dt}));
         return 35'(($signed({{2{p[32]}}, p}) + 35'sd4) >>> 3);
      end
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [53:0] v);
      if (v > 54'sd2147483647) return 32'sh7fffffff;
      if (v < -54'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   logic signed [34:0] mop;
   logic [16:0] mw;
   logic signed [53:0] prod;

   always_comb begin
      case (m_cnt_ff)
         3'd0: begin mop = gr_ff; mw = w_ff; end
         3'd1: begin mop = ar_ff; mw = WEIGHT_ONE - w_ff; end
         3'd2: begin mop = gp_ff; mw = w_ff; end
         default: begin mop = ap_ff; mw = WEIGHT_ONE - w_ff; end
      endcase
      prod = 54'(mop * $signed({1'b0, mw}));
   end

   assign status.sqrt_done = (sq_cnt_ff == 5'd29);
   assign status.cordic_done = (c_cnt_ff == LAST_STEP);
   assign status.mul_done = (m_cnt_ff == 3'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff <= '0; pitch_ff <= '0; yaw_ff <= '0;
      end else begin
         if (cmd.load) begin
            ax_ff <= req_accel_x; ay_ff <= req_accel_y; az_ff <= req_accel_z;
            gx_ff <= req_rate_x; gy_ff <= req_rate_y; gz_ff <= req_rate_z;
            dt_ff <= req_time_step;
            w_ff <= (csr_gyro_weight > WEIGHT_ONE) ? WEIGHT_ONE : csr_gyro_weight;
            rem_ff <= '0; root_ff <= '0; sq_cnt_ff <= '0;
            rad_ff <= {sumsq, 28'd0};
         end
         if (cmd.sqrt_step) begin
            rad_ff <= rad_in; rem_ff <= rem_in; root_ff <= root_in;
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         if (cmd.cordic_init) begin
            logic signed [33:0] rx, ry, px, py;
            rx = 34'(az_ff) <<< 14; ry = 34'(ay_ff) <<< 14;
            px = $signed({4'd0, root_ff}); py = -(34'(ax_ff) <<< 14);
            c_cnt_ff <= '0;
            if (rx < 0) begin
               x0_ff <= -rx; y0_ff <= -ry; z0_ff <= (ry >= 0) ? PI_Q24 : -PI_Q24;
            end else begin
               x0_ff <= rx; y0_ff <= ry; z0_ff <= '0;
            end
            x1_ff <= px; y1_ff <= py; z1_ff <= '0;
         end
         if (cmd.cordic_step) begin
            c_cnt_ff <= c_cnt_ff + 5'd1;
            if (y0_ff >= 0) begin
               x0_ff <= x0_ff + fshift(y0_ff, c_cnt_ff);
               y0_ff <= y0_ff - fshift(x0_ff, c_cnt_ff);
               z0_ff <= z0_ff + atan_q24(c_cnt_ff);
            end else begin
               x0_ff <= x0_ff - fshift(y0_ff, c_cnt_ff);
               y0_ff <= y0_ff + fshift(x0_ff, c_cnt_ff);
               z0_ff <= z0_ff - atan_q24(c_cnt_ff);
            end
            if (y1_ff >= 0) begin
               x1_ff <= x1_ff + fshift(y1_ff, c_cnt_ff);
               y1_ff <= y1_ff - fshift(x1_ff, c_cnt_ff);
               z1_ff <= z1_ff + atan_q24(c_cnt_ff);
            end else begin
               x1_ff <= x1_ff - fshift(y1_ff, c_cnt_ff);
               y1_ff <= y1_ff + fshift(x1_ff, c_cnt_ff);
               z1_ff <= z1_ff - atan_q24(c_cnt_ff);
            end
         end
         if (cmd.blend) begin
            logic signed [34:0] gyaw;
            gr_ff <= 35'(roll_ff) + incr(gx_ff, dt_ff);
            gp_ff <= 35'(pitch_ff) + incr(gy_ff, dt_ff);
            gyaw = 35'(yaw_ff) + incr(gz_ff, dt_ff);
            yaw_ff <= sat(54'(gyaw));
            // Both operands zero give an angle of zero.
            ar_ff <= (az_ff == 0 && ay_ff == 0) ? '0 : 35'(z0_ff);
            ap_ff <= (ax_ff == 0 && root_ff == 0) ? '0 : 35'(z1_ff);
            m_cnt_ff <= '0;
            acc_ff <= 54'sd32768;
         end
         if (cmd.mul_step) begin
            m_cnt_ff <= m_cnt_ff + 3'd1;
            case (m_cnt_ff)
               3'd0: acc_ff <= acc_ff + prod;
               3'd1: begin
                  roll_ff <= sat((acc_ff + prod) >>> 16);
                  acc_ff <= 54'sd32768;
               end
               3'd2: acc_ff <= acc_ff + prod;
               3'd3: pitch_ff <= sat((acc_ff + prod) >>> 16);
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- rtl/complementary_attitude_filter.sv -----
// Complementary attitude filter: roll, pitch and yaw from accel and gyro samples.
// Each transaction runs the 30-digit square root, then CORDIC_STEPS (at most 30)
// CORDIC iterations, then the blend, before its response is given.
// One transaction at a time: a new one is accepted only in idle, with the last result taken.
// Synchronous reset clears the angles to zero and the gyro weight to 64225.
`timescale 1ns / 1ps
module complementary_attitude_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   input  logic [15:0] req_time_step,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_roll_out,
   output logic signed [31:0] rsp_pitch_out,
   output logic signed [31:0] rsp_yaw_out,
   input  logic csr_write_enable,
   input  logic [16:0] csr_write_data
);
   import caf_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [16:0] gyro_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) gyro_weight_ff <= WEIGHT_RESET;
      else if (csr_write_enable) gyro_weight_ff <= csr_write_data;
   end

   caf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   caf_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_gyro_weight(gyro_weight_ff),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y),
      .req_accel_z(req_accel_z), .req_rate_x(req_rate_x),
      .req_rate_y(req_rate_y), .req_rate_z(req_rate_z),
      .req_time_step(req_time_step),
      .roll_angle(rsp_roll_out), .pitch_angle(rsp_pitch_out),
      .yaw_angle(rsp_yaw_out)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("accepted while busy");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_yaw_out)) else $error("result moved");
endmodule

// ----- tb/complementary_attitude_filter_tb.sv -----
// Self-checking testbench for the complementary attitude filter.
`timescale 1ns / 1ps
module complementary_attitude_filter_tb;
   import caf_pkg::*;

   localparam int STEPS = 16;
   localparam int RANDOM_ITEMS = 1550;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      logic [15:0] dt;
   } sample_type;

   typedef struct {
      logic signed [31:0] roll, pitch, yaw;
   } attitude_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] req_rate_x = 0, req_rate_y = 0, req_rate_z = 0;
   logic [15:0] req_time_step = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_roll_out, rsp_pitch_out, rsp_yaw_out;
   logic csr_write_enable = 0;
   logic [16:0] csr_write_data = 0;
   logic req_accepted = 0;

   complementary_attitude_filter #(.CORDIC_STEPS(STEPS)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   sample_type pending_samples[$];
   attitude_type expected_attitudes[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   longint cycles = 0;

   // Predictor state.
   logic signed [31:0] roll_q, pitch_q, yaw_q;
   logic [16:0] weight_q;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root, bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_q24(i[4:0]));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_q24(i[4:0]));
         end
      end
      return z;
   endfunction

   function automatic longint rate_increment(longint rate, longint dt);
      return shr_floor(rate * dt + 4, 3);
   endfunction

   function automatic longint mix(longint gyro, longint accel, longint w);
      return sat32(shr_floor(w * gyro + (longint'(WEIGHT_ONE) - w) * accel + 32768, 16));
   endfunction

   function automatic attitude_type update_attitude(sample_type s);
      attitude_type a;
      longint w, ax, ay, az, r, acc_roll, acc_pitch;
      longint unsigned sumsq;
      ax = s.ax; ay = s.ay; az = s.az;
      w = (weight_q > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_q);
      sumsq = ay * ay + az * az;
      r = int_sqrt(sumsq << 28);
      acc_roll = vector_angle(ay * 16384, az * 16384);
      acc_pitch = vector_angle(-ax * 16384, r);
      roll_q = 32'(mix(longint'(roll_q) + rate_increment(s.gx, s.dt), acc_roll, w));
      pitch_q = 32'(mix(longint'(pitch_q) + rate_increment(s.gy, s.dt), acc_pitch, w));
      yaw_q = 32'(sat32(longint'(yaw_q) + rate_increment(s.gz, s.dt)));
      a.roll = roll_q; a.pitch = pitch_q; a.yaw = yaw_q;
      return a;
   endfunction

   // Driver: holds a transaction until it is accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_accepted) begin
            // keep holding
         end else if (pending_samples.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            sample_type s;
            s = pending_samples.pop_front();
            req_valid <= 1;
            req_accel_x <= s.ax; req_accel_y <= s.ay; req_accel_z <= s.az;
            req_rate_x <= s.gx; req_rate_y <= s.gy; req_rate_z <= s.gz;
            req_time_step <= s.dt;
            expected_attitudes.push_back(update_attitude(s));
         end else begin
            req_valid <= 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_attitudes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response transaction");
         end else begin
            attitude_type e;
            e = expected_attitudes.pop_front();
            if (rsp_roll_out !== e.roll || rsp_pitch_out !== e.pitch ||
                rsp_yaw_out !== e.yaw) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           e.roll, e.pitch, e.yaw,
                           rsp_roll_out, rsp_pitch_out, rsp_yaw_out);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_valid || expected_attitudes.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(logic [16:0] w);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= w;
      @(negedge clock);
      csr_write_enable <= 0;
      weight_q = w;
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_sample(logic [15:0] ax, ay, az, gx, gy, gz, dt);
      sample_type s;
      s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy; s.gz = gz; s.dt = dt;
      pending_samples.push_back(s);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            add_sample(rand_field(), rand_field(), rand_field(), rand_field(),
                       rand_field(), rand_field(), rand_field());
         else
            add_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [16:0] weights[6];
      weights = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd65535, 17'd1};
      roll_q = '0; pitch_q = '0; yaw_q = '0;
      weight_q = WEIGHT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, both-zero operands, negative x with both y signs.
      add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
      add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      add_sample(16'sd100, 16'sd0, -16'sd200, 16'sd10, -16'sd10, 16'sd5, 16'd1000);
      add_sample(-16'sd100, -16'sd1, -16'sd200, -16'sd10, 16'sd10, -16'sd5, 16'd1000);
      add_sample(16'd0, 16'sd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      add_sample(16'd0, -16'sd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      add_sample(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      // Drive yaw with full-scale rates both ways.
      for (int i = 0; i < 6; i++)
         add_sample(16'd0, 16'd0, 16'sd100, 16'd0, 16'd0, 16'h7FFF, 16'hFFFF);
      for (int i = 0; i < 6; i++)
         add_sample(16'd0, 16'd0, 16'sd100, 16'd0, 16'd0, 16'h8000, 16'hFFFF);
      wait_idle();

      // Weight of one makes roll and pitch follow the gyro path alone.
      write_weight(WEIGHT_ONE);
      for (int i = 0; i < 5; i++)
         add_sample(16'd0, 16'd0, 16'sd100, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (int k = 0; k < 6; k++) begin
            write_weight(ph == 0 && k == 5 ? 17'($urandom_range(131071)) : weights[k]);
            add_random(RANDOM_ITEMS / 24);
            wait_idle();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
